>>> hw/rtl/tcb_pkg.sv
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types, constants and saturating helpers for the tracer cell binning
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcb_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 32;
  localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
  localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int IDX_W       = (COL_W > ROW_W) ? COL_W : ROW_W;

  localparam int POS_W     = 32;
  localparam int DIM_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int COUNT_W   = 16;
  localparam int TSUM_W    = 32;
  localparam int TSQ_W     = 48;
  localparam int TIME_W    = 16;
  localparam int SQ_W      = 2 * TIME_W;
  localparam int RATIO_W   = 32;
  localparam int DIV_CNT_W = $clog2(RATIO_W);

  localparam logic [DIM_W-1:0] COL_LIMIT =
    DIM_W'((MAX_COLUMNS > 63) ? 63 : MAX_COLUMNS);
  localparam logic [DIM_W-1:0] ROW_LIMIT =
    DIM_W'((MAX_ROWS > 63) ? 63 : MAX_ROWS);
  localparam logic [CELL_W-1:0]    CELL_LAST = CELL_W'(CELLS - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(RATIO_W - 1);

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_INV_SPACING_X = 3'd2,
    REG_INV_SPACING_Y = 3'd3,
    REG_COLUMNS       = 3'd4,
    REG_ROWS          = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_FLAGGED = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MAP,
    S_RD_START,
    S_WR_START,
    S_RD_END,
    S_WR_END,
    S_RD_CELL,
    S_DIVIDE
  } state_t;

  typedef struct packed {
    logic                      operation;
    logic signed [POS_W-1:0]   start_x;
    logic signed [POS_W-1:0]   start_y;
    logic signed [POS_W-1:0]   end_x;
    logic signed [POS_W-1:0]   end_y;
    logic                      escaped_flag;
    logic [TIME_W-1:0]         travel_time;
    logic [9:0]                cell_index;
  } request_t;

  typedef struct packed {
    status_t              status;
    logic [COUNT_W-1:0]   start_count;
    logic [COUNT_W-1:0]   end_count;
    logic [COUNT_W-1:0]   start_flag_count;
    logic [COUNT_W-1:0]   end_flag_count;
    logic [TSUM_W-1:0]    time_sum;
    logic [TSQ_W-1:0]     time_square_sum;
    logic [RATIO_W-1:0]   gather_ratio;
  } result_t;

  typedef struct packed {
    logic [COUNT_W-1:0] start_count;
    logic [COUNT_W-1:0] end_count;
    logic [COUNT_W-1:0] start_flag_count;
    logic [COUNT_W-1:0] end_flag_count;
    logic [TSUM_W-1:0]  time_sum;
    logic [TSQ_W-1:0]   time_square_sum;
  } cell_t;

  typedef struct packed {
    logic              start_off;
    logic              end_off;
    logic [CELL_W-1:0] start_cell;
    logic [CELL_W-1:0] end_cell;
  } map_t;

  function automatic logic [COUNT_W-1:0] sat_inc16(input logic [COUNT_W-1:0] v);
    return (v == '1) ? v : v + COUNT_W'(1);
  endfunction

  function automatic logic [TSUM_W-1:0] sat_add_sum(input logic [TSUM_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
    logic [TSUM_W:0] s;
    s = {1'b0, a} + (TSUM_W + 1)'(b);
    return s[TSUM_W] ? '1 : s[TSUM_W-1:0];
  endfunction

  function automatic logic [TSQ_W-1:0] sat_add_sq(input logic [TSQ_W-1:0] a,
                                                  input logic [SQ_W-1:0] b);
    logic [TSQ_W:0] s;
    s = {1'b0, a} + (TSQ_W + 1)'(b);
    return s[TSQ_W] ? '1 : s[TSQ_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tcb_cell_store.sv
// ----------------------------------------------------------------------------
// tcb_cell_store
// Per-cell counter memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_cell_store
  import tcb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [CELL_W-1:0] waddr,
  input  wire cell_t             wdata,
  input  wire logic [CELL_W-1:0] raddr,
  output cell_t                  rdata
);

  cell_t mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcb_cell_map.sv
// ----------------------------------------------------------------------------
// tcb_cell_map
// Three-stage shared pipeline that maps the four tracer coordinates to grid
// indices, one axis per cycle, then forms the start and end cell numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_cell_map
  import tcb_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire request_t                request,
  input  wire logic signed [POS_W-1:0] origin_x,
  input  wire logic signed [POS_W-1:0] origin_y,
  input  wire logic [POS_W-1:0]        inv_x,
  input  wire logic [POS_W-1:0]        inv_y,
  input  wire logic [DIM_W-1:0]        cols_lim,
  input  wire logic [DIM_W-1:0]        rows_lim,
  output logic                         done,
  output map_t                         map
);

  logic [POS_W-1:0] pos [4];
  logic [1:0]       step;
  logic             feeding;

  logic             s1_valid;
  logic [1:0]       s1_axis;
  logic             s1_neg;
  logic [POS_W-1:0] s1_mag;
  logic [POS_W-1:0] s1_inv;

  logic               s2_valid;
  logic [1:0]         s2_axis;
  logic               s2_neg;
  logic [2*POS_W-1:0] s2_prod;

  logic             axis_off [4];
  logic [IDX_W-1:0] axis_idx [4];
  logic             combine;

  logic [POS_W-1:0]  cur_pos;
  logic [POS_W-1:0]  cur_org;
  logic [POS_W:0]    diff;
  logic [POS_W:0]    diff_neg;
  logic [DIM_W-1:0]  s2_limit;
  logic              s2_off;
  logic [IDX_W+DIM_W-1:0] start_row;
  logic [IDX_W+DIM_W-1:0] end_row;

  assign cur_pos  = pos[step];
  assign cur_org  = step[0] ? origin_y : origin_x;
  assign diff     = {cur_pos[POS_W-1], cur_pos} - {cur_org[POS_W-1], cur_org};
  assign diff_neg = -diff;

  assign s2_limit = s2_axis[0] ? rows_lim : cols_lim;
  assign s2_off   = (s2_neg && (s2_prod != '0)) ||
                    (s2_prod[2*POS_W-1:POS_W] >= POS_W'(s2_limit));

  assign start_row = axis_idx[1] * cols_lim;
  assign end_row   = axis_idx[3] * cols_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      feeding  <= 1'b0;
      step     <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      combine  <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= feeding;
      s2_valid <= s1_valid;
      combine  <= s2_valid && (s2_axis == 2'd3);
      done     <= combine;
      if (start) begin
        feeding <= 1'b1;
        step    <= '0;
      end else if (feeding) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          feeding <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pos[0] <= request.start_x;
      pos[1] <= request.start_y;
      pos[2] <= request.end_x;
      pos[3] <= request.end_y;
    end
    s1_axis <= step;
    s1_neg  <= diff[POS_W];
    s1_mag  <= diff[POS_W] ? diff_neg[POS_W-1:0] : diff[POS_W-1:0];
    s1_inv  <= step[0] ? inv_y : inv_x;
    s2_axis <= s1_axis;
    s2_neg  <= s1_neg;
    s2_prod <= s1_mag * s1_inv;
    if (s2_valid) begin
      axis_off[s2_axis] <= s2_off;
      axis_idx[s2_axis] <= s2_prod[POS_W +: IDX_W];
    end
    if (combine) begin
      map <= map_t'{
        start_off:  axis_off[0] | axis_off[1],
        end_off:    axis_off[2] | axis_off[3],
        start_cell: CELL_W'(start_row) + CELL_W'(axis_idx[0]),
        end_cell:   CELL_W'(end_row) + CELL_W'(axis_idx[2])
      };
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcb_ratio_div.sv
// ----------------------------------------------------------------------------
// tcb_ratio_div
// Restoring divider, one quotient bit per cycle, for the gather ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_ratio_div
  import tcb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [RATIO_W-1:0] dividend,
  input  wire logic [COUNT_W-1:0] divisor,
  output logic                    done,
  output logic [RATIO_W-1:0]      quotient
);

  logic                 running;
  logic [DIV_CNT_W-1:0] count;
  logic [COUNT_W-1:0]   rem;
  logic [COUNT_W-1:0]   dsor;
  logic [COUNT_W:0]     trial;
  logic [COUNT_W:0]     trial_sub;
  logic                 fits;

  assign trial     = {rem, quotient[RATIO_W-1]};
  assign trial_sub = trial - {1'b0, dsor};
  assign fits      = (trial >= {1'b0, dsor});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= '0;
      end else if (running) begin
        count <= count + DIV_CNT_W'(1);
        if (count == DIV_LAST) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsor     <= divisor;
    end else if (running) begin
      rem      <= fits ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quotient <= {quotient[RATIO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tracer_cell_binning.sv
// ----------------------------------------------------------------------------
// tracer_cell_binning
// Two-dimensional histogram of tracer start and end cells.
//
// Requests enter on request when start is high and busy is low. An accumulate
// request maps the start and end positions to grid cells and updates the
// per-cell saturating counters; a read request returns one cell's counters
// and the end/start ratio in Q16.16. Every request gives exactly one result,
// shown on result for one cycle with result_valid high; the receiver cannot
// stall and must take it then. The block handles one request at a time.
// Accumulate: the result follows the shared axis-mapping pipeline (four axes
// through one multiplier) and up to two read-modify-write passes over the
// counter memory: none when the start cell is off the grid, one when only the
// end cell is, two otherwise.
// Read: the result waits for the bit-serial ratio divider.
// After reset busy stays high while the counter memory is cleared one cell
// per cycle; configuration writes are taken at any time through cfg_write,
// cfg_index and cfg_data and must only be made when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tracer_cell_binning
  import tcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire request_t             request,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output logic                      result_valid,
  output result_t                   result
);

  logic signed [POS_W-1:0] origin_x;
  logic signed [POS_W-1:0] origin_y;
  logic [POS_W-1:0]        inv_spacing_x;
  logic [POS_W-1:0]        inv_spacing_y;
  logic [DIM_W-1:0]        columns;
  logic [DIM_W-1:0]        rows;
  logic [DIM_W-1:0]        cols_lim;
  logic [DIM_W-1:0]        rows_lim;

  state_t            state;
  state_t            state_next;
  logic [CELL_W-1:0] clear_addr;
  request_t          req;
  logic [SQ_W-1:0]   square;
  logic              in_range;
  cell_t             cell_data;

  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr;
  cell_t             mem_wdata;
  logic [CELL_W-1:0] mem_raddr;
  cell_t             mem_rdata;
  cell_t             start_upd;
  cell_t             end_upd;

  logic               accept;
  logic               map_start;
  logic               map_done;
  map_t               map;
  logic               div_start;
  logic               div_done;
  logic [RATIO_W-1:0] quotient;
  logic               finish;
  status_t            finish_status;
  result_t            result_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign cols_lim = (columns > COL_LIMIT) ? COL_LIMIT : columns;
  assign rows_lim = (rows > ROW_LIMIT) ? ROW_LIMIT : rows;

  tcb_cell_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tcb_cell_map u_map (
    .clk      (clk),
    .rst      (rst),
    .start    (map_start),
    .request  (request),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .inv_x    (inv_spacing_x),
    .inv_y    (inv_spacing_y),
    .cols_lim (cols_lim),
    .rows_lim (rows_lim),
    .done     (map_done),
    .map      (map)
  );

  tcb_ratio_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({mem_rdata.end_count, COUNT_W'(0)}),
    .divisor  (mem_rdata.start_count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    start_upd = mem_rdata;
    if (req.escaped_flag || map.end_off) begin
      start_upd.start_flag_count = sat_inc16(mem_rdata.start_flag_count);
    end else begin
      start_upd.start_count = sat_inc16(mem_rdata.start_count);
    end
  end

  always_comb begin
    end_upd = mem_rdata;
    if (req.escaped_flag) begin
      end_upd.end_flag_count = sat_inc16(mem_rdata.end_flag_count);
    end else begin
      end_upd.end_count       = sat_inc16(mem_rdata.end_count);
      end_upd.time_sum        = sat_add_sum(mem_rdata.time_sum, req.travel_time);
      end_upd.time_square_sum = sat_add_sq(mem_rdata.time_square_sum, square);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mem_we        = 1'b0;
    mem_waddr     = map.start_cell;
    mem_wdata     = start_upd;
    mem_raddr     = request.cell_index[CELL_W-1:0];
    map_start     = 1'b0;
    div_start     = 1'b0;
    finish        = 1'b0;
    finish_status = ST_COUNTED;
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clear_addr;
        mem_wdata = '0;
        if (clear_addr == CELL_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (request.operation == OP_READ) begin
            state_next = S_RD_CELL;
          end else begin
            map_start  = 1'b1;
            state_next = S_MAP;
          end
        end
      end
      S_MAP: begin
        if (map_done) begin
          if (map.start_off) begin
            finish        = 1'b1;
            finish_status = ST_SKIPPED;
            state_next    = S_IDLE;
          end else begin
            state_next = S_RD_START;
          end
        end
      end
      S_RD_START: begin
        mem_raddr  = map.start_cell;
        state_next = S_WR_START;
      end
      S_WR_START: begin
        mem_we = 1'b1;
        if (map.end_off) begin
          finish        = 1'b1;
          finish_status = ST_FLAGGED;
          state_next    = S_IDLE;
        end else begin
          state_next = S_RD_END;
        end
      end
      S_RD_END: begin
        mem_raddr  = map.end_cell;
        state_next = S_WR_END;
      end
      S_WR_END: begin
        mem_we        = 1'b1;
        mem_waddr     = map.end_cell;
        mem_wdata     = end_upd;
        finish        = 1'b1;
        finish_status = ST_COUNTED;
        state_next    = S_IDLE;
      end
      S_RD_CELL: begin
        div_start  = 1'b1;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (div_done) begin
          finish        = 1'b1;
          finish_status = ST_READ;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result_next        = '0;
    result_next.status = finish_status;
    if ((finish_status == ST_READ) && in_range) begin
      result_next.start_count      = cell_data.start_count;
      result_next.end_count        = cell_data.end_count;
      result_next.start_flag_count = cell_data.start_flag_count;
      result_next.end_flag_count   = cell_data.end_flag_count;
      result_next.time_sum         = cell_data.time_sum;
      result_next.time_square_sum  = cell_data.time_square_sum;
      result_next.gather_ratio     = (cell_data.start_count == '0) ? '0 : quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      inv_spacing_x <= POS_W'(65536);
      inv_spacing_y <= POS_W'(65536);
      columns       <= DIM_W'(32);
      rows          <= DIM_W'(32);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      origin_x      <= cfg_data;
        REG_ORIGIN_Y:      origin_y      <= cfg_data;
        REG_INV_SPACING_X: inv_spacing_x <= cfg_data;
        REG_INV_SPACING_Y: inv_spacing_y <= cfg_data;
        REG_COLUMNS:       columns       <= cfg_data[DIM_W-1:0];
        REG_ROWS:          rows          <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr   <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= finish;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + CELL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= request;
      square   <= request.travel_time * request.travel_time;
      in_range <= (32'(request.cell_index) < CELLS);
    end
    if (state == S_RD_CELL) begin
      cell_data <= mem_rdata;
    end
    if (finish) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tcb_checker.sv
// ----------------------------------------------------------------------------
// tcb_checker
// Port-level checks on request acceptance, result timing and accumulate result contents.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_checker
  import tcb_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    start,
  input wire logic    busy,
  input wire logic    result_valid,
  input wire result_t result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!busy && $past(busy)))
    else $error("result not at the end of a busy period");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  a_accum_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.status != ST_READ)) |->
      ((result.start_count == '0) && (result.gather_ratio == '0) &&
       (result.time_square_sum == '0)))
    else $error("accumulate result carries counter data");

endmodule

bind tracer_cell_binning tcb_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire

>>> tb/sv/binning_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binning_scoreboard_pkg
// Scoreboard for the tracer cell binning block. It keeps its own copy of the
// grid registers and of every per-cell counter, works out the result of each
// accepted request, and checks the results in the order they arrive.
// ----------------------------------------------------------------------------
package binning_scoreboard_pkg;
  import tcb_pkg::*;

  function automatic int unsigned in_use_limit(logic [DIM_W-1:0] n, int unsigned cap);
    return (n > cap) ? cap : n;
  endfunction

  class binning_scoreboard;
    logic signed [POS_W-1:0] org_x, org_y;
    logic [CFG_W-1:0]        inv_x, inv_y;
    logic [DIM_W-1:0]        n_cols, n_rows;

    logic [COUNT_W-1:0] starts      [CELLS];
    logic [COUNT_W-1:0] ends        [CELLS];
    logic [COUNT_W-1:0] start_flags [CELLS];
    logic [COUNT_W-1:0] end_flags   [CELLS];
    logic [TSUM_W-1:0]  t_sums      [CELLS];
    logic [TSQ_W-1:0]   t_sq_sums   [CELLS];

    result_t outcomes_due [$];
    int      errors;

    function new();
      org_x  = '0;
      org_y  = '0;
      inv_x  = 32'h0001_0000;
      inv_y  = 32'h0001_0000;
      n_cols = 6'd32;
      n_rows = 6'd32;
      foreach (starts[i]) begin
        starts[i]      = '0;
        ends[i]        = '0;
        start_flags[i] = '0;
        end_flags[i]   = '0;
        t_sums[i]      = '0;
        t_sq_sums[i]   = '0;
      end
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] d);
      case (idx)
        REG_ORIGIN_X:      org_x  = d;
        REG_ORIGIN_Y:      org_y  = d;
        REG_INV_SPACING_X: inv_x  = d;
        REG_INV_SPACING_Y: inv_y  = d;
        REG_COLUMNS:       n_cols = d[DIM_W-1:0];
        REG_ROWS:          n_rows = d[DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function bit axis_cell(logic [POS_W-1:0] pos, logic signed [POS_W-1:0] org,
                           logic [CFG_W-1:0] inv, int unsigned lim,
                           output int unsigned idx);
      longint    diff;
      bit [63:0] mag;
      bit [63:0] prod;
      idx  = 0;
      diff = longint'($signed(pos)) - longint'(org);
      mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
      prod = mag * 64'(inv);
      if (diff < 0 && prod != 0) return 1'b0;
      if (prod[63:32] >= lim) return 1'b0;
      idx = prod[63:32];
      return 1'b1;
    endfunction

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function result_t apply_request(request_t r);
      result_t     res;
      int unsigned cols, rws, sx, sy, ex, ey, qs, qe, c;
      logic [63:0] ratio;
      logic [31:0] tsq;
      logic [32:0] tsum;
      logic [48:0] sqsum;
      res  = '0;
      cols = in_use_limit(n_cols, MAX_COLUMNS);
      rws  = in_use_limit(n_rows, MAX_ROWS);
      if (r.operation == OP_READ) begin
        res.status = ST_READ;
        c = r.cell_index;
        if (c < CELLS) begin
          res.start_count      = starts[c];
          res.end_count        = ends[c];
          res.start_flag_count = start_flags[c];
          res.end_flag_count   = end_flags[c];
          res.time_sum         = t_sums[c];
          res.time_square_sum  = t_sq_sums[c];
          if (starts[c] != 0) begin
            ratio = {32'b0, ends[c], 16'b0} / 64'(starts[c]);
            res.gather_ratio = (ratio > 64'hFFFF_FFFF) ? '1 : ratio[31:0];
          end
        end
        return res;
      end
      if (!axis_cell(r.start_x, org_x, inv_x, cols, sx) ||
          !axis_cell(r.start_y, org_y, inv_y, rws, sy)) begin
        res.status = ST_SKIPPED;
        return res;
      end
      qs = sx + sy * cols;
      if (!axis_cell(r.end_x, org_x, inv_x, cols, ex) ||
          !axis_cell(r.end_y, org_y, inv_y, rws, ey)) begin
        start_flags[qs] = bump(start_flags[qs]);
        res.status = ST_FLAGGED;
        return res;
      end
      qe = ex + ey * cols;
      if (!r.escaped_flag) begin
        tsq   = 32'(r.travel_time) * 32'(r.travel_time);
        tsum  = {1'b0, t_sums[qe]} + 33'(r.travel_time);
        sqsum = {1'b0, t_sq_sums[qe]} + 49'(tsq);
        starts[qs]    = bump(starts[qs]);
        ends[qe]      = bump(ends[qe]);
        t_sums[qe]    = tsum[32] ? '1 : tsum[31:0];
        t_sq_sums[qe] = sqsum[48] ? '1 : sqsum[47:0];
      end else begin
        start_flags[qs] = bump(start_flags[qs]);
        end_flags[qe]   = bump(end_flags[qe]);
      end
      res.status = ST_COUNTED;
      return res;
    endfunction

    function void note_request(request_t r);
      outcomes_due.push_back(apply_request(r));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (outcomes_due.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %h", $time, got);
        return;
      end
      want = outcomes_due.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("start_count", 64'(want.start_count), 64'(got.start_count));
      compare_field("end_count", 64'(want.end_count), 64'(got.end_count));
      compare_field("start_flag_count", 64'(want.start_flag_count),
                    64'(got.start_flag_count));
      compare_field("end_flag_count", 64'(want.end_flag_count),
                    64'(got.end_flag_count));
      compare_field("time_sum", 64'(want.time_sum), 64'(got.time_sum));
      compare_field("time_square_sum", 64'(want.time_square_sum),
                    64'(got.time_square_sum));
      compare_field("gather_ratio", 64'(want.gather_ratio), 64'(got.gather_ratio));
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction
  endclass

endpackage

>>> tb/sv/tb_tracer_cell_binning.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tracer_cell_binning
// Drives accumulate and read requests into the tracer cell binning block
// under several grid settings and sender pacing, and checks every result
// against the scoreboard's own histogram. One cell is hit by a run of
// identical tracers.
// ----------------------------------------------------------------------------
module tb_tracer_cell_binning;
  import tcb_pkg::*;
  import binning_scoreboard_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOT_REPEATS = 32;
  localparam int GAP_MAX     = 40;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 start        = 1'b0;
  logic                 busy;
  request_t             request      = '0;
  logic                 cfg_write    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 result_valid;
  result_t              result;

  int gap_pct      = 0;
  int quiet_cycles = 0;
  binning_scoreboard bin_board;

  tracer_cell_binning u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) bin_board.check_result(result);
      if (start && !busy) bin_board.note_request(request);
    end
  end

  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_tracer_cell_binning: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input request_t r);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, GAP_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (bin_board.pending() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    bin_board.write_reg(idx, d);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_grid(input logic [31:0] ox, oy, ix, iy, cols, rws);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_INV_SPACING_X, ix);
    write_reg(REG_INV_SPACING_Y, iy);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, rws);
  endtask

  function automatic request_t tracer(input logic [31:0] sx, sy, ex, ey,
                                      input logic flag, input logic [15:0] tt);
    request_t r;
    r              = '0;
    r.operation    = OP_ACCUMULATE;
    r.start_x      = sx;
    r.start_y      = sy;
    r.end_x        = ex;
    r.end_y        = ey;
    r.escaped_flag = flag;
    r.travel_time  = tt;
    r.cell_index   = 10'($urandom);
    return r;
  endfunction

  function automatic request_t cell_read(input logic [9:0] c);
    request_t r;
    r            = '0;
    r.operation  = OP_READ;
    r.cell_index = c;
    return r;
  endfunction

  // Mostly land near the grid, sometimes just below the origin or past the far edge.
  function automatic logic [31:0] pick_pos(input logic signed [31:0] org,
                                           input logic [31:0] inv, input int unsigned n);
    longint span;
    longint diff;
    if ($urandom_range(0, 4) == 0) return $urandom;
    span = (inv == 0) ? 64'sh1_0000_0000 : ((longint'(n) <<< 32) / longint'(inv)) + 1;
    span = span + span / 8 + 2;
    if (span > 64'd4294967295) span = 64'd4294967295;
    diff = longint'($urandom_range(0, 32'(span))) -
           longint'($urandom_range(0, 32'(span / 16)));
    return 32'(longint'(org) + diff);
  endfunction

  function automatic request_t random_request();
    request_t    r;
    int unsigned cols, rws, cells;
    cols = in_use_limit(bin_board.n_cols, MAX_COLUMNS);
    rws  = in_use_limit(bin_board.n_rows, MAX_ROWS);
    r.operation    = ($urandom_range(0, 99) < 22) ? OP_READ : OP_ACCUMULATE;
    r.start_x      = pick_pos(bin_board.org_x, bin_board.inv_x, cols);
    r.start_y      = pick_pos(bin_board.org_y, bin_board.inv_y, rws);
    r.end_x        = pick_pos(bin_board.org_x, bin_board.inv_x, cols);
    r.end_y        = pick_pos(bin_board.org_y, bin_board.inv_y, rws);
    r.escaped_flag = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 7))
      0:       r.travel_time = '0;
      1:       r.travel_time = '1;
      default: r.travel_time = 16'($urandom);
    endcase
    cells = cols * rws;
    if (cells > 0 && $urandom_range(0, 1) == 1) begin
      r.cell_index = 10'($urandom_range(0, cells - 1));
    end else begin
      r.cell_index = 10'($urandom);
    end
    return r;
  endfunction

  task automatic run_random(input int n);
    int lane;
    lane = $urandom_range(0, 2);
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) begin
        case ((lane + k / 50) % 3)
          0:       gap_pct = 0;
          1:       gap_pct = 77;
          default: gap_pct = 23;
        endcase
      end
      send(random_request());
    end
    settle();
  endtask

  task automatic random_grid();
    logic [31:0] near_x, near_y, ix, iy, cols, rws;
    near_x = 32'($urandom_range(0, 32'h0028_0000)) - 32'h0014_0000;
    near_y = 32'($urandom_range(0, 32'h0028_0000)) - 32'h0014_0000;
    if ($urandom_range(0, 3) == 0) near_x = $urandom;
    if ($urandom_range(0, 3) == 0) near_y = $urandom;
    ix   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(32'h2000, 32'h4_0000);
    iy   = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(32'h2000, 32'h4_0000);
    cols = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32);
    rws  = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32);
    write_grid(near_x, near_y, ix, iy, cols, rws);
  endtask

  initial begin
    bin_board = new();
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // reset grid: unit cells, 32 by 32 from the origin
    gap_pct = 0;
    send(cell_read(10'd0));
    send(tracer(32'h0000_0000, 32'h0000_0000, 32'h001F_FFFF, 32'h001F_FFFF, 1'b0, 16'hFFFF));
    send(tracer(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 16'h0010));
    send(tracer(32'h0000_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 16'h0010));
    send(tracer(32'h0020_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 16'h0020));
    send(tracer(32'h0000_0000, 32'h0020_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 16'h0020));
    send(tracer(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, 1'b0, 16'h0030));
    send(tracer(32'h0005_8000, 32'h0003_4000, 32'hFFFF_FFFF, 32'h0001_0000, 1'b1, 16'h1234));
    send(tracer(32'h0005_8000, 32'h0003_4000, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0, 16'h00FF));
    send(tracer(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000, 1'b1, 16'hFFFF));
    send(tracer(32'h0001_0000, 32'h0001_0000, 32'h001F_FFFF, 32'h001F_FFFF, 1'b0, 16'h0000));
    send(tracer(32'h0002_0000, 32'h0000_0000, 32'h001F_FFFF, 32'h001F_FFFF, 1'b0, 16'h0001));
    send(tracer(32'h001F_0000, 32'h001F_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'h8000));
    send(cell_read(10'd1023));
    send(cell_read(10'd0));
    send(cell_read(10'd33));
    send(cell_read(10'd66));
    send(cell_read(10'd101));
    send(cell_read(10'd2));
    send(cell_read(10'd512));
    settle();

    // hit one cell back to back with the longest travel time
    for (int k = 0; k < HOT_REPEATS; k++) begin
      send(tracer(32'h0004_0000, 32'h0004_0000, 32'h0004_8000, 32'h0004_8000, 1'b0, 16'hFFFF));
    end
    send(cell_read(10'd132));
    settle();

    run_random(200);

    write_grid(32'hFFF6_0000, 32'h0003_8000, 32'h0002_0000, 32'h0000_4000, 32'd20, 32'd7);
    run_random(250);

    write_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'd1, 32'd32);
    run_random(150);

    write_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0, 32'd63);
    run_random(100);

    write_grid(32'hFFFF_0000, 32'h0000_0000, 32'h0000_8000, 32'h0100_0000, 32'hFFFF_FFFF,
               32'd1);
    run_random(150);

    repeat (5) begin
      random_grid();
      run_random(150);
    end

    settle();
    repeat (40) @(posedge clk);
    if (bin_board.errors == 0) begin
      $display("tb_tracer_cell_binning: clean");
    end else begin
      $display("tb_tracer_cell_binning: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/tcb_pkg.sv
hw/rtl/tcb_cell_store.sv
hw/rtl/tcb_cell_map.sv
hw/rtl/tcb_ratio_div.sv
hw/rtl/tracer_cell_binning.sv
hw/rtl/tcb_checker.sv
tb/sv/binning_scoreboard_pkg.sv
tb/sv/tb_tracer_cell_binning.sv
